// ===== rtl/rtp_pkg.sv =====
// shared types, character codes and lookup tables of the ringtone text parser
// no dependencies
package rtp_pkg;

  localparam logic [1:0] ST_TONE = 2'd0;
  localparam logic [1:0] ST_LAST = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_SHARP = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_B     = 8'h62;

  localparam logic [3:0] PAUSE_PITCH = 4'd12;
  localparam logic [9:0] ACC_MAX     = 10'd1023;
  localparam logic [2:0] DEF_LEN_LOG = 3'd2;  // duration 4
  localparam logic [1:0] DEF_OCT_IDX = 2'd2;  // octave 6
  localparam logic [4:0] DEF_TEMPO   = 5'd8;  // 63 bpm
  localparam int unsigned FIFO_DEPTH = 2;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] pitch;
    logic [1:0] oct;
    logic [2:0] dlog;
    logic       dot;
    logic [4:0] tempo;
    logic [6:0] note;
  } rtp_event_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] idx;
  } rtp_lut_t;

  localparam logic [11:0] PITCH_HZ [4][13] = '{
    '{12'd261, 12'd277, 12'd293, 12'd311, 12'd329, 12'd349, 12'd369,
      12'd392, 12'd415, 12'd440, 12'd466, 12'd493, 12'd0},
    '{12'd523, 12'd554, 12'd587, 12'd622, 12'd659, 12'd698, 12'd739,
      12'd783, 12'd830, 12'd880, 12'd932, 12'd987, 12'd0},
    '{12'd1046, 12'd1108, 12'd1174, 12'd1244, 12'd1318, 12'd1396, 12'd1479,
      12'd1567, 12'd1661, 12'd1760, 12'd1864, 12'd1975, 12'd0},
    '{12'd2093, 12'd2217, 12'd2349, 12'd2489, 12'd2637, 12'd2793, 12'd2959,
      12'd3135, 12'd3322, 12'd3520, 12'd3729, 12'd3951, 12'd0}};

  // whole note in ms for each allowed tempo, 240000 / bpm
  localparam logic [13:0] WHOLE_MS [32] = '{
    14'd9600, 14'd8571, 14'd7741, 14'd6857, 14'd6000, 14'd5333, 14'd4800, 14'd4285,
    14'd3809, 14'd3428, 14'd3000, 14'd2666, 14'd2400, 14'd2142, 14'd1920, 14'd1714,
    14'd1500, 14'd1333, 14'd1200, 14'd1066, 14'd960,  14'd842,  14'd750,  14'd676,
    14'd600,  14'd533,  14'd480,  14'd424,  14'd377,  14'd335,  14'd300,  14'd266};

  function automatic rtp_lut_t tempo_lookup(logic [9:0] v);
    rtp_lut_t r;
    r.hit = 1'b1;
    unique case (v)
      10'd25:  r.idx = 5'd0;  10'd28:  r.idx = 5'd1;  10'd31:  r.idx = 5'd2;
      10'd35:  r.idx = 5'd3;  10'd40:  r.idx = 5'd4;  10'd45:  r.idx = 5'd5;
      10'd50:  r.idx = 5'd6;  10'd56:  r.idx = 5'd7;  10'd63:  r.idx = 5'd8;
      10'd70:  r.idx = 5'd9;  10'd80:  r.idx = 5'd10; 10'd90:  r.idx = 5'd11;
      10'd100: r.idx = 5'd12; 10'd112: r.idx = 5'd13; 10'd125: r.idx = 5'd14;
      10'd140: r.idx = 5'd15; 10'd160: r.idx = 5'd16; 10'd180: r.idx = 5'd17;
      10'd200: r.idx = 5'd18; 10'd225: r.idx = 5'd19; 10'd250: r.idx = 5'd20;
      10'd285: r.idx = 5'd21; 10'd320: r.idx = 5'd22; 10'd355: r.idx = 5'd23;
      10'd400: r.idx = 5'd24; 10'd450: r.idx = 5'd25; 10'd500: r.idx = 5'd26;
      10'd565: r.idx = 5'd27; 10'd635: r.idx = 5'd28; 10'd715: r.idx = 5'd29;
      10'd800: r.idx = 5'd30; 10'd900: r.idx = 5'd31;
      default: begin
        r.hit = 1'b0;
        r.idx = 5'd0;
      end
    endcase
    return r;
  endfunction

  function automatic rtp_lut_t dur_lookup(logic [9:0] v);
    rtp_lut_t r;
    r.hit = 1'b1;
    unique case (v)
      10'd1:  r.idx = 5'd0;
      10'd2:  r.idx = 5'd1;
      10'd4:  r.idx = 5'd2;
      10'd8:  r.idx = 5'd3;
      10'd16: r.idx = 5'd4;
      10'd32: r.idx = 5'd5;
      default: begin
        r.hit = 1'b0;
        r.idx = 5'd0;
      end
    endcase
    return r;
  endfunction

  function automatic rtp_lut_t letter_lookup(logic [7:0] c);
    rtp_lut_t r;
    r.hit = 1'b1;
    unique case (c)
      8'h63: r.idx = 5'd0;
      8'h64: r.idx = 5'd2;
      8'h65: r.idx = 5'd4;
      8'h66: r.idx = 5'd5;
      8'h67: r.idx = 5'd7;
      8'h61: r.idx = 5'd9;
      8'h62, 8'h68: r.idx = 5'd11;
      8'h70: r.idx = 5'(PAUSE_PITCH);
      default: begin
        r.hit = 1'b0;
        r.idx = 5'd0;
      end
    endcase
    return r;
  endfunction

  // decimal accumulate with saturation
  function automatic logic [9:0] acc_next(logic [9:0] acc, logic [3:0] dig);
    logic [13:0] v;
    v = 14'({acc, 3'b000}) + 14'({acc, 1'b0}) + 14'(dig);
    return (v > 14'(ACC_MAX)) ? ACC_MAX : v[9:0];
  endfunction

endpackage

// ===== rtl/rtp_fifo.sv =====
// small two-pointer queue between the parser front and the tone back end
// depends on rtp_pkg for the depth
module rtp_fifo import rtp_pkg::*; #(
  parameter type T = rtp_event_t
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  input  logic pop_i,
  output T     data_o,
  output logic full_o,
  output logic empty_o
);
  localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  T                mem_q [FIFO_DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end
endmodule

// ===== rtl/rtp_front.sv =====
// parser front: walks the song text one byte at a time and emits tone events
// depends on rtp_pkg for character codes, lookups and the event type
module rtp_front import rtp_pkg::*; #(
  parameter int unsigned MAX_NOTES   = 128,
  parameter int unsigned TITLE_LIMIT = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] char_i,
  output logic       ev_push_o,
  output rtp_event_t ev_o
);
  localparam int unsigned TW = $clog2(TITLE_LIMIT + 1);
  localparam int unsigned CW = $clog2(MAX_NOTES + 1);

  typedef enum logic [3:0] {
    PH_TITLE, PH_KEY, PH_EQ, PH_FIRST, PH_NUM, PH_TSTART, PH_TDUR,
    PH_TLETTER, PH_TOCT, PH_TDOT, PH_SKIP
  } phase_e;

  phase_e        ph_q, ph_d;
  logic [TW-1:0] tcnt_q, tcnt_d;
  logic [1:0]    slot_q, slot_d;
  logic [9:0]    acc_q, acc_d;
  logic [2:0]    dlen_q, dlen_d, tlen_q, tlen_d;
  logic [1:0]    doct_q, doct_d, toct_q, toct_d;
  logic          tlen_set_q, tlen_set_d, toct_set_q, toct_set_d;
  logic [4:0]    tempo_q, tempo_d;
  logic [3:0]    pitch_q, pitch_d;
  logic          dot_q, dot_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic          is_dig, do_fail, do_end, do_next, do_letter, restart;
  logic [3:0]    dig;
  logic [7:0]    key, delim;
  logic [8:0]    cnt_ext;
  rtp_lut_t      dur_r, tmp_r, let_r;

  assign is_dig  = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign dig     = char_i[3:0];
  assign key     = (slot_q == 2'd0) ? CH_D : ((slot_q == 2'd1) ? CH_O : CH_B);
  assign delim   = (slot_q >= 2'd2) ? CH_COLON : CH_COMMA;
  assign dur_r   = dur_lookup(acc_q);
  assign tmp_r   = tempo_lookup(acc_q);
  assign let_r   = letter_lookup(char_i);
  assign cnt_ext = 9'(cnt_q);

  always_comb begin
    ph_d = ph_q; tcnt_d = tcnt_q; slot_d = slot_q; acc_d = acc_q;
    dlen_d = dlen_q; doct_d = doct_q; tempo_d = tempo_q;
    tlen_d = tlen_q; tlen_set_d = tlen_set_q; toct_d = toct_q; toct_set_d = toct_set_q;
    pitch_d = pitch_q; dot_d = dot_q; cnt_d = cnt_q;
    do_fail = 1'b0; do_end = 1'b0; do_next = 1'b0; do_letter = 1'b0; restart = 1'b0;
    ev_push_o = 1'b0;
    ev_o = '0;
    if (take_i) begin
      unique case (ph_q)
        PH_TITLE: begin
          if (char_i == CH_COLON) begin
            slot_d = 2'd0;
            ph_d = PH_KEY;
          end else if (char_i != CH_NUL && tcnt_q < TW'(TITLE_LIMIT)) begin
            tcnt_d = tcnt_q + TW'(1);
          end else begin
            do_fail = 1'b1;
          end
        end
        PH_KEY: begin
          if (char_i == key) ph_d = PH_EQ;
          else if (char_i == delim) do_next = 1'b1;
          else do_fail = 1'b1;
        end
        PH_EQ: begin
          if (char_i == CH_EQ) ph_d = PH_FIRST;
          else do_fail = 1'b1;
        end
        PH_FIRST: begin
          if (is_dig) begin
            acc_d = 10'(dig);
            ph_d = PH_NUM;
          end else begin
            do_fail = 1'b1;
          end
        end
        PH_NUM: begin
          if (is_dig) begin
            acc_d = acc_next(acc_q, dig);
          end else if (char_i != delim) begin
            do_fail = 1'b1;
          end else begin
            unique case (slot_q)
              2'd0: begin
                if (dur_r.hit) dlen_d = dur_r.idx[2:0];
                else do_fail = 1'b1;
              end
              2'd1: begin
                if (acc_q >= 10'd4 && acc_q <= 10'd7) doct_d = acc_q[1:0];
                else do_fail = 1'b1;
              end
              default: begin
                if (tmp_r.hit) tempo_d = tmp_r.idx;
                else do_fail = 1'b1;
              end
            endcase
            do_next = !do_fail;
          end
        end
        PH_TSTART: begin
          if (cnt_q >= CW'(MAX_NOTES)) do_fail = 1'b1;
          else if (is_dig) begin
            acc_d = 10'(dig);
            ph_d = PH_TDUR;
          end else do_letter = 1'b1;
        end
        PH_TDUR: begin
          if (is_dig) acc_d = acc_next(acc_q, dig);
          else if (!dur_r.hit) do_fail = 1'b1;
          else begin
            tlen_d = dur_r.idx[2:0];
            tlen_set_d = 1'b1;
            do_letter = 1'b1;
          end
        end
        PH_TLETTER: begin
          if (char_i == CH_SHARP && (pitch_q == 4'd0 || pitch_q == 4'd2 ||
              pitch_q == 4'd5 || pitch_q == 4'd7 || pitch_q == 4'd9)) begin
            pitch_d = pitch_q + 4'd1;
          end else if (is_dig) begin
            acc_d = 10'(dig);
            ph_d = PH_TOCT;
          end else if (char_i == CH_DOT) begin
            dot_d = 1'b1;
            ph_d = PH_TDOT;
          end else do_end = 1'b1;
        end
        PH_TOCT: begin
          if (is_dig) acc_d = acc_next(acc_q, dig);
          else if (acc_q < 10'd4 || acc_q > 10'd7) do_fail = 1'b1;
          else begin
            toct_d = acc_q[1:0];
            toct_set_d = 1'b1;
            if (char_i == CH_DOT) begin
              dot_d = 1'b1;
              ph_d = PH_TDOT;
            end else do_end = 1'b1;
          end
        end
        PH_TDOT: do_end = 1'b1;
        PH_SKIP: begin
          if (char_i == CH_NUL) restart = 1'b1;
        end
        default: do_fail = 1'b1;
      endcase

      if (do_letter) begin
        if (let_r.hit) begin
          pitch_d = let_r.idx[3:0];
          ph_d = PH_TLETTER;
        end else do_fail = 1'b1;
      end

      if (do_next) begin
        if (slot_q < 2'd2) begin
          slot_d = slot_q + 2'd1;
          ph_d = PH_KEY;
        end else begin
          tlen_d = '0; tlen_set_d = 1'b0; toct_d = '0; toct_set_d = 1'b0;
          pitch_d = '0; dot_d = 1'b0; acc_d = '0;
          ph_d = PH_TSTART;
        end
      end

      if (do_end) begin
        if (char_i != CH_COMMA && char_i != CH_NUL) begin
          do_fail = 1'b1;
        end else begin
          ev_push_o = 1'b1;
          ev_o.status = (char_i == CH_NUL) ? ST_LAST : ST_TONE;
          ev_o.pitch  = pitch_d;
          ev_o.oct    = toct_set_d ? toct_d : doct_q;
          ev_o.dlog   = tlen_set_d ? tlen_d : dlen_q;
          ev_o.dot    = dot_d;
          ev_o.tempo  = tempo_q;
          ev_o.note   = cnt_ext[6:0];
          if (char_i == CH_NUL) restart = 1'b1;
          else begin
            cnt_d = cnt_q + CW'(1);
            tlen_d = '0; tlen_set_d = 1'b0; toct_d = '0; toct_set_d = 1'b0;
            pitch_d = '0; dot_d = 1'b0; acc_d = '0;
            ph_d = PH_TSTART;
          end
        end
      end

      if (do_fail) begin
        ev_push_o = 1'b1;
        ev_o = '0;
        ev_o.status = ST_ERR;
        if (char_i == CH_NUL) restart = 1'b1;
        else ph_d = PH_SKIP;
      end

      if (restart) begin
        ph_d = PH_TITLE; tcnt_d = '0; slot_d = '0; acc_d = '0;
        dlen_d = DEF_LEN_LOG; doct_d = DEF_OCT_IDX; tempo_d = DEF_TEMPO;
        tlen_d = '0; tlen_set_d = 1'b0; toct_d = '0; toct_set_d = 1'b0;
        pitch_d = '0; dot_d = 1'b0; cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_TITLE; tcnt_q <= '0; slot_q <= '0; acc_q <= '0;
      dlen_q <= DEF_LEN_LOG; doct_q <= DEF_OCT_IDX; tempo_q <= DEF_TEMPO;
      tlen_q <= '0; tlen_set_q <= 1'b0; toct_q <= '0; toct_set_q <= 1'b0;
      pitch_q <= '0; dot_q <= 1'b0; cnt_q <= '0;
    end else begin
      ph_q <= ph_d; tcnt_q <= tcnt_d; slot_q <= slot_d; acc_q <= acc_d;
      dlen_q <= dlen_d; doct_q <= doct_d; tempo_q <= tempo_d;
      tlen_q <= tlen_d; tlen_set_q <= tlen_set_d; toct_q <= toct_d;
      toct_set_q <= toct_set_d; pitch_q <= pitch_d; dot_q <= dot_d; cnt_q <= cnt_d;
    end
  end
endmodule

// ===== rtl/rtp_back.sv =====
// tone back end: turns a queued event into frequency and length, holds the result
// depends on rtp_pkg for the event type and the pitch and tempo tables
module rtp_back import rtp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rtp_event_t  ev_i,
  input  logic        ev_avail_i,
  output logic        ev_take_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [11:0] frequency_hz_o,
  output logic [13:0] length_ms_o,
  output logic [6:0]  note_number_o,
  output logic [1:0]  status_o
);
  logic        valid_q;
  logic [13:0] whole, base, half;
  logic [11:0] freq;
  logic        is_err;

  assign is_err    = (ev_i.status == ST_ERR);
  assign whole     = WHOLE_MS[ev_i.tempo];
  assign base      = whole >> ev_i.dlog;
  assign half      = ev_i.dot ? (whole >> (ev_i.dlog + 3'd1)) : 14'd0;
  assign freq      = PITCH_HZ[ev_i.oct][(ev_i.pitch > PAUSE_PITCH) ? PAUSE_PITCH : ev_i.pitch];
  assign ev_take_o = ev_avail_i && (!valid_q || pop_i);
  assign empty_o   = !valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ev_take_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_take_o) begin
      frequency_hz_o <= is_err ? 12'd0 : freq;
      length_ms_o    <= is_err ? 14'd0 : base + half;
      note_number_o  <= is_err ? 7'd0 : ev_i.note;
      status_o       <= ev_i.status;
    end
  end
endmodule

// ===== rtl/ringtone_text_parser.sv =====
// ringtone text parser: one text byte per cycle while not full, one result per closed tone or error
// a result passes through the event queue and then the output register after the byte that closes the tone
// throughput: one byte each cycle, limited only by the result side draining
// the front parser, a two-entry event queue and the output register decouple the sides
// reset: asynchronous active low, restarts parsing at the title with default settings
module ringtone_text_parser import rtp_pkg::*; #(
  parameter int unsigned MAX_NOTES   = 128,
  parameter int unsigned TITLE_LIMIT = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_code_i,
  output logic        empty,
  input  logic        pop,
  output logic [11:0] frequency_hz_o,
  output logic [13:0] length_ms_o,
  output logic [6:0]  note_number_o,
  output logic [1:0]  status_o
);
  logic       take, ev_push, q_empty, q_pop;
  rtp_event_t ev_in, ev_out;

  assign take = push && !full;

  rtp_front #(.MAX_NOTES(MAX_NOTES), .TITLE_LIMIT(TITLE_LIMIT)) u_front (
    .clk_i, .rst_ni, .take_i(take), .char_i(char_code_i),
    .ev_push_o(ev_push), .ev_o(ev_in)
  );

  rtp_fifo #(.T(rtp_event_t)) u_fifo (
    .clk_i, .rst_ni, .push_i(ev_push), .data_i(ev_in), .pop_i(q_pop),
    .data_o(ev_out), .full_o(full), .empty_o(q_empty)
  );

  rtp_back u_back (
    .clk_i, .rst_ni, .ev_i(ev_out), .ev_avail_i(!q_empty), .ev_take_o(q_pop),
    .pop_i(pop), .empty_o(empty), .frequency_hz_o, .length_ms_o,
    .note_number_o, .status_o
  );
endmodule

// ===== rtl/rtp_checker.sv =====
// port-level checks of the ringtone text parser result side
// depends on rtp_pkg for status codes; bound to ringtone_text_parser
module rtp_assert import rtp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [11:0] frequency_hz_o,
  input logic [13:0] length_ms_o,
  input logic [6:0]  note_number_o,
  input logic [1:0]  status_o
);
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_o == ST_TONE || status_o == ST_LAST || status_o == ST_ERR))
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == ST_ERR) |->
      (frequency_hz_o == 12'd0 && length_ms_o == 14'd0 && note_number_o == 7'd0))
    else $error("error item carries tone data");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ST_ERR) |-> (length_ms_o <= 14'd14400 && length_ms_o != 14'd0))
    else $error("tone length out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(length_ms_o)))
    else $error("stalled item changed");
endmodule

bind ringtone_text_parser rtp_assert u_rtp_assert (
  .clk_i, .rst_ni, .empty, .pop, .frequency_hz_o, .length_ms_o,
  .note_number_o, .status_o
);
